@@ rtl/lcmr_pkg.sv @@
package lcmr_pkg;

	localparam int MSG_MAX    = 30;
	localparam int ADDR_BYTES = 7;
	localparam int LEN_W      = $clog2(MSG_MAX + 1);
	localparam int IDX_W      = $clog2(MSG_MAX);
	localparam int LEN_W1     = LEN_W + 1;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 56;

	localparam logic [7:0] TYPE_HEARTBEAT      = 8'h0D;
	localparam logic [7:0] TYPE_CONNECT_RESULT = 8'h13;
	localparam logic [7:0] TYPE_RESET_IND      = 8'h14;
	localparam logic [7:0] TYPE_PIN_REQUEST    = 8'h15;
	localparam logic [7:0] TYPE_CONN_REQUEST   = 8'h16;
	localparam logic [7:0] TYPE_CLOSE_RESULT   = 8'h1A;
	localparam logic [7:0] TYPE_NONE           = 8'hFF;
	localparam logic [7:0] HANDLE_NONE         = 8'hFF;

	typedef enum logic [1:0] {
		OP_BYTE       = 2'd0,
		OP_READ_REPLY = 2'd1,
		OP_READ_ADDR  = 2'd2,
		OP_NOP        = 2'd3
	} op_t;

	typedef enum logic {
		CFG_STREAM_MODE  = 1'b0,
		CFG_AWAITED_TYPE = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH,
		ST_COPY,
		ST_RDWAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
		logic copy;
		logic reply_rd;
		logic reply_take;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic stream;
		logic parse_done;
		logic copy_go;
		logic copy_last;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/length_checksum_message_receiver_unit.sv @@
// Channel  Direction  Handshake          Payload
// s        in         s_tvalid/s_tready  s_tuser: opcode; s_tdata: data_byte, read_index
// m        out        m_tvalid/m_tready  m_tdata: status and result fields
// cfg      in         cfg_we             cfg_index, cfg_wdata
//
// A read or a non-final byte runs load, execute and emit before the result
// register is loaded; a reply read adds a wait state for the registered RAM
// read, and a byte that finishes a message adds a finish state, plus a copy
// state moving each argument into the reply store for the awaited reply.
// Reset is asynchronous and needs no clearing pass. A stalled result holds
// in the output register while the next transaction is taken and worked on.
module length_checksum_message_receiver_unit
	import lcmr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte[7:0], read_index[12:8]
	input  logic [1:0]            s_tuser,   // opcode[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // stream_valid[0], stream_byte[8:1],
	                                         // message_done[9], message_good[10],
	                                         // message_type[18:11], reset_event[19],
	                                         // pin_event[20], connect_event[21],
	                                         // reply_captured[22],
	                                         // connection_handle[30:23],
	                                         // read_data[38:31], error_count[54:39]
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	lcmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lcmr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_op     (s_tuser),
		.in_byte   (s_tdata[7:0]),
		.in_idx    (s_tdata[12:8]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ rtl/lcmr_ram.sv @@
module lcmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lcmr_ctrl.sv @@
module lcmr_ctrl
	import lcmr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stat_t  stat,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.op == OP_BYTE && !stat.stream && stat.parse_done) begin
					state_d = ST_FINISH;
				end else if (stat.op == OP_READ_REPLY) begin
					state_d = ST_RDWAIT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_FINISH: begin
				state_d = stat.copy_go ? ST_COPY : ST_EMIT;
			end
			ST_COPY: begin
				if (stat.copy_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_RDWAIT: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.reply_rd = (stat.op == OP_READ_REPLY);
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
			end
			ST_RDWAIT: begin
				cmd.reply_take = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/lcmr_datapath.sv @@
module lcmr_datapath
	import lcmr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [1:0]            in_op,
	input  logic [7:0]            in_byte,
	input  logic [4:0]            in_idx,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_wdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic             stream_mode_q;
	logic [7:0]       awaited_q;
	logic             reply_mark_q;
	logic [7:0]       handle_q;
	logic [15:0]      drop_q;
	logic [LEN_W-1:0] exp_len_q;
	logic [LEN_W-1:0] rcv_q;
	logic [7:0]       addr_q [ADDR_BYTES];
	logic             cp_v_s1;
	logic             m_valid_q;

	op_t              op_q;
	logic [7:0]       byte_q;
	logic [4:0]       idx_q;
	logic [15:0]      sum_q;
	logic [7:0]       type_q;
	logic [7:0]       arg1_q;
	logic [7:0]       arg2_q;
	logic [7:0]       chk_hi_q;
	logic [7:0]       sh_q [ADDR_BYTES];
	logic [LEN_W-1:0] nargs_q;
	logic [LEN_W-1:0] copy_q;
	logic [IDX_W-1:0] cp_idx_s1;
	logic             res_sv_q;
	logic [7:0]       res_sb_q;
	logic             res_done_q;
	logic             res_good_q;
	logic [7:0]       res_type_q;
	logic             res_rst_q;
	logic             res_pin_q;
	logic             res_con_q;
	logic [7:0]       res_rd_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic              parse_byte;
	logic [LEN_W1-1:0] rcv_p1;
	logic [LEN_W1-1:0] rcv_p2;
	logic [LEN_W1-1:0] exp_ext;
	logic              parse_done;
	logic [15:0]       neg_sum;
	logic              good;
	logic [LEN_W-1:0]  nargs_w;
	logic              capture;
	logic              len_ok;
	logic              idx_in_msg;
	logic [7:0]        addr_rd;
	logic              msg_we;
	logic [IDX_W-1:0]  msg_raddr;
	logic [7:0]        msg_rdata;
	logic [7:0]        rep_rdata;

	assign parse_byte = (op_q == OP_BYTE) && !stream_mode_q && (exp_len_q != '0);
	assign rcv_p1     = LEN_W1'(rcv_q) + LEN_W1'(1);
	assign rcv_p2     = LEN_W1'(rcv_q) + LEN_W1'(2);
	assign exp_ext    = LEN_W1'(exp_len_q);
	assign parse_done = (exp_len_q != '0) && (rcv_p1 == exp_ext);
	assign neg_sum    = ~sum_q + 16'd1;
	assign nargs_w    = exp_len_q - LEN_W'(3);
	assign good       = (exp_len_q >= LEN_W'(3)) && (chk_hi_q == neg_sum[15:8])
	                    && (byte_q == neg_sum[7:0]);
	assign capture    = good && (type_q != TYPE_HEARTBEAT) && (type_q == awaited_q)
	                    && !reply_mark_q;
	assign len_ok     = (byte_q != 8'd0) && (byte_q <= 8'(MSG_MAX));
	assign idx_in_msg = 8'(idx_q) < 8'(MSG_MAX);

	always_comb begin
		addr_rd = 8'd0;
		for (int i = 0; i < ADDR_BYTES; i++) begin
			if (8'(idx_q) == 8'(i)) begin
				addr_rd = addr_q[i];
			end
		end
	end

	assign stat.op         = op_q;
	assign stat.stream     = stream_mode_q;
	assign stat.parse_done = parse_done;
	assign stat.copy_go    = capture && (nargs_w != '0);
	assign stat.copy_last  = (LEN_W1'(copy_q) + LEN_W1'(1)) == LEN_W1'(nargs_q);
	assign stat.out_free   = !m_valid_q || out_ready;

	assign msg_we    = cmd.exec && parse_byte;
	assign msg_raddr = IDX_W'(copy_q + LEN_W'(1));

	lcmr_ram #(
		.WIDTH (8),
		.DEPTH (MSG_MAX)
	) u_msg_ram (
		.clk   (clk),
		.we    (msg_we),
		.waddr (IDX_W'(rcv_q)),
		.wdata (byte_q),
		.re    (cmd.copy),
		.raddr (msg_raddr),
		.rdata (msg_rdata)
	);

	lcmr_ram #(
		.WIDTH (8),
		.DEPTH (MSG_MAX)
	) u_reply_ram (
		.clk   (clk),
		.we    (cp_v_s1),
		.waddr (cp_idx_s1),
		.wdata (msg_rdata),
		.re    (cmd.reply_rd),
		.raddr (IDX_W'(idx_q)),
		.rdata (rep_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_mode_q <= 1'b0;
			awaited_q     <= TYPE_NONE;
			reply_mark_q  <= 1'b0;
			handle_q      <= HANDLE_NONE;
			drop_q        <= '0;
			exp_len_q     <= '0;
			rcv_q         <= '0;
			cp_v_s1       <= 1'b0;
			m_valid_q     <= 1'b0;
			for (int i = 0; i < ADDR_BYTES; i++) begin
				addr_q[i] <= 8'd0;
			end
		end else begin
			cp_v_s1 <= cmd.copy;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_STREAM_MODE: begin
						stream_mode_q <= cfg_wdata[0];
						exp_len_q     <= '0;
						rcv_q         <= '0;
					end
					CFG_AWAITED_TYPE: begin
						awaited_q    <= cfg_wdata;
						reply_mark_q <= 1'b0;
					end
					default: begin
						awaited_q <= awaited_q;
					end
				endcase
			end
			if (cmd.exec && (op_q == OP_BYTE) && !stream_mode_q) begin
				if (exp_len_q == '0) begin
					if (len_ok) begin
						exp_len_q <= LEN_W'(byte_q);
					end
				end else begin
					rcv_q <= LEN_W'(rcv_p1);
				end
			end
			if (cmd.finish) begin
				exp_len_q <= '0;
				rcv_q     <= '0;
				if (!good) begin
					drop_q <= drop_q + 16'd1;
				end else begin
					if (type_q == TYPE_PIN_REQUEST || type_q == TYPE_CONN_REQUEST) begin
						for (int i = 0; i < ADDR_BYTES; i++) begin
							if (8'(i) < 8'(nargs_w)) begin
								addr_q[i] <= sh_q[i];
							end
						end
					end
					if (type_q == TYPE_CONNECT_RESULT && nargs_w >= LEN_W'(2)
					    && arg1_q != 8'd0) begin
						handle_q <= arg2_q;
					end
					if (type_q == TYPE_CLOSE_RESULT) begin
						handle_q <= HANDLE_NONE;
					end
					if (capture) begin
						reply_mark_q <= 1'b1;
					end
				end
			end
			if (cmd.emit) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op_t'(in_op);
			byte_q     <= in_byte;
			idx_q      <= in_idx;
			res_sv_q   <= 1'b0;
			res_sb_q   <= 8'd0;
			res_done_q <= 1'b0;
			res_good_q <= 1'b0;
			res_type_q <= 8'd0;
			res_rst_q  <= 1'b0;
			res_pin_q  <= 1'b0;
			res_con_q  <= 1'b0;
			res_rd_q   <= 8'd0;
		end
		if (cmd.exec) begin
			case (op_q)
				OP_BYTE: begin
					if (stream_mode_q) begin
						res_sv_q <= 1'b1;
						res_sb_q <= byte_q;
					end else if (exp_len_q == '0) begin
						sum_q <= 16'(byte_q);
					end else begin
						if (rcv_q == LEN_W'(0)) begin
							type_q <= byte_q;
						end
						if (rcv_q == LEN_W'(1)) begin
							arg1_q <= byte_q;
						end
						if (rcv_q == LEN_W'(2)) begin
							arg2_q <= byte_q;
						end
						for (int i = 0; i < ADDR_BYTES; i++) begin
							if (8'(rcv_q) == 8'(i + 1)) begin
								sh_q[i] <= byte_q;
							end
						end
						if (rcv_p2 < exp_ext) begin
							sum_q <= sum_q + 16'(byte_q);
						end
						if (rcv_p2 == exp_ext) begin
							chk_hi_q <= byte_q;
						end
					end
				end
				OP_READ_ADDR: begin
					res_rd_q <= addr_rd;
				end
				default: begin
					res_rd_q <= res_rd_q;
				end
			endcase
		end
		if (cmd.finish) begin
			res_done_q <= 1'b1;
			res_type_q <= type_q;
			res_good_q <= good;
			res_rst_q  <= good && (type_q == TYPE_RESET_IND);
			res_pin_q  <= good && (type_q == TYPE_PIN_REQUEST);
			res_con_q  <= good && (type_q == TYPE_CONN_REQUEST);
			nargs_q    <= nargs_w;
			copy_q     <= '0;
		end
		if (cmd.copy) begin
			copy_q    <= copy_q + LEN_W'(1);
			cp_idx_s1 <= IDX_W'(copy_q);
		end
		if (cmd.reply_take) begin
			res_rd_q <= idx_in_msg ? rep_rdata : 8'd0;
		end
		if (cmd.emit) begin
			m_data_q <= {1'b0, drop_q, res_rd_q, handle_q, reply_mark_q, res_con_q,
			             res_pin_q, res_rst_q, res_type_q, res_good_q, res_done_q,
			             res_sb_q, res_sv_q};
		end
	end

	assign out_valid = m_valid_q;
	assign out_data  = m_data_q;

endmodule
